/* design/wave_vertex_displace_core_macros.svh */
// assertion macros for the wave vertex displace core
// used by the top level; needs nothing else
`ifndef WAVE_VERTEX_DISPLACE_CORE_MACROS_SVH
`define WAVE_VERTEX_DISPLACE_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define WVD_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("wave vertex displace: same-cycle check failed");

// next-cycle implication, checked out of reset
`define WVD_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("wave vertex displace: next-cycle check failed");

`endif

/* design/wvd_pkg.sv */
// shared types, widths, register codes and the cosine weight table builder
// for the wave vertex displace core; depends on nothing
package wvd_pkg;

  // build-time sizing
  localparam int COS_TABLE_DEPTH = 1024;
  localparam int COORD_WIDTH     = 20;
  localparam int KW              = $clog2(COS_TABLE_DEPTH);

  // fixed field widths
  localparam int GRID_W    = 17;
  localparam int CRD_W     = 20;
  localparam int SPAN_W    = 19;
  localparam int DW        = 26;
  localparam int GC_W      = GRID_W + 1;
  localparam int GCA_W     = GC_W + CRD_W;
  localparam int W_W       = 17;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_AMP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 3'd6;

  // cosine table arithmetic, Q30
  localparam logic [63:0]        PI_Q30  = 64'd3373259426;
  localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic [CRD_W-1:0]  origin_x;
    logic [CRD_W-1:0]  origin_y;
    logic [SPAN_W-1:0] span_x;
    logic [SPAN_W-1:0] span_y;
    logic [CRD_W-1:0]  window_top;
    logic [CRD_W-1:0]  wave_amp;
    logic [SPAN_W-1:0] half_width;
  } cfg_t;

  // per-vertex values carried alongside the band divider
  typedef struct packed {
    logic [DW-1:0]    ox;
    logic [DW-1:0]    oy;
    logic             band;
    logic [GCA_W-1:0] gca;
  } side_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] pos_x;
    logic [COORD_WIDTH-1:0] pos_y;
    logic                   in_band;
  } res_t;

  typedef logic [W_W-1:0] cos_rom_t [COS_TABLE_DEPTH];

  // cosine over the first half period by truncated taylor series
  function automatic logic signed [63:0] cos_half_q30(input logic [63:0] k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (k * PI_Q30) / 64'(COS_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = 64'(ONE_Q30);
    sum  = ONE_Q30;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if ((n & 1) != 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    return sum;
  endfunction

  // raised cosine weight (cos + 1) / 2 in Q1.16, clamped
  function automatic logic [W_W-1:0] cos_weight(input logic [63:0] k);
    logic signed [63:0] c;
    logic signed [63:0] w;
    if ((k << 1) <= 64'(COS_TABLE_DEPTH)) begin
      c = cos_half_q30(k);
    end else begin
      c = -cos_half_q30(64'(COS_TABLE_DEPTH) - k);
    end
    w = (ONE_Q30 + c + 64'sd16384) >>> 15;
    if (w < 0) begin
      w = 0;
    end
    if (w > 64'sd65536) begin
      w = 64'sd65536;
    end
    return w[W_W-1:0];
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
      rom[k] = cos_weight(64'(k));
    end
    return rom;
  endfunction

endpackage

/* design/wvd_map.sv */
// front stages: grid to screen mapping, wave position, distance and band test
// depends on wvd_pkg
module wvd_map (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  wvd_pkg::cfg_t            cfg,
  input  logic                     in_valid,
  input  logic [wvd_pkg::GRID_W-1:0] grid_x,
  input  logic [wvd_pkg::GRID_W-1:0] grid_y,
  input  logic [wvd_pkg::GRID_W-1:0] progress,
  output logic                     out_valid,
  output wvd_pkg::side_t           out_side,
  output logic [wvd_pkg::DW-1:0]   out_ad
);

  localparam int DW     = wvd_pkg::DW;
  localparam int PX_W   = wvd_pkg::SPAN_W + wvd_pkg::GRID_W + 1;
  localparam int SUM_W  = wvd_pkg::SPAN_W + 2;
  localparam int PWP_W  = wvd_pkg::GRID_W + SUM_W + 1;
  localparam int GC_W   = wvd_pkg::GC_W;
  localparam int GCA_W  = wvd_pkg::GCA_W;

  // stage 1: products with rounding folded in
  logic [PX_W-1:0]  px_r, py_r, px_nxt, py_nxt;
  logic [PWP_W-1:0] pw_r, pw_nxt;
  logic [SUM_W-1:0] band_span;
  logic [GC_W-1:0]  gc_r, gc_nxt;
  logic             vld1_r;

  always_comb begin
    px_nxt    = PX_W'(cfg.span_x) * PX_W'(grid_x) + PX_W'(32768);
    py_nxt    = PX_W'(cfg.span_y) * PX_W'(grid_y) + PX_W'(32768);
    band_span = SUM_W'(cfg.span_y) + (SUM_W'(cfg.half_width) << 1);
    pw_nxt    = PWP_W'(progress) * PWP_W'(band_span) + PWP_W'(32768);
    gc_nxt    = {1'b0, grid_x} - GC_W'(32768);
  end

  // stage 2: screen position, wave start and centered amplitude product
  logic [DW-1:0]    ox2_r, oy2_r, wp2_r, ox2_nxt, oy2_nxt, wp2_nxt;
  logic [GCA_W-1:0] gca2_r, gca2_nxt;
  logic             vld2_r;

  always_comb begin
    ox2_nxt  = DW'($signed(cfg.origin_x)) + DW'(px_r[PX_W-1:16]);
    oy2_nxt  = DW'($signed(cfg.origin_y)) + DW'(py_r[PX_W-1:16]);
    wp2_nxt  = DW'($signed(cfg.window_top)) - DW'(cfg.half_width)
             + DW'(pw_r[PWP_W-1:16]);
    gca2_nxt = $signed(gc_r) * $signed(cfg.wave_amp);
  end

  // stage 3: signed distance from the wave center
  logic [DW-1:0]    ox3_r, oy3_r, d3_r, d3_nxt;
  logic [GCA_W-1:0] gca3_r;
  logic             vld3_r;

  assign d3_nxt = oy2_r - wp2_r;

  // stage 4: magnitude and band test
  logic [DW-1:0] ad4_r, ad4_nxt;
  logic          band4_r, band4_nxt;
  logic [DW-1:0] ox4_r, oy4_r;
  logic [GCA_W-1:0] gca4_r;
  logic          vld4_r;

  always_comb begin
    ad4_nxt   = d3_r[DW-1] ? (DW'(0) - d3_r) : d3_r;
    band4_nxt = (cfg.half_width != '0) && (ad4_nxt < DW'(cfg.half_width));
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pw_r    <= pw_nxt;
      gc_r    <= gc_nxt;
      ox2_r   <= ox2_nxt;
      oy2_r   <= oy2_nxt;
      wp2_r   <= wp2_nxt;
      gca2_r  <= gca2_nxt;
      ox3_r   <= ox2_r;
      oy3_r   <= oy2_r;
      d3_r    <= d3_nxt;
      gca3_r  <= gca2_r;
      ad4_r   <= ad4_nxt;
      band4_r <= band4_nxt;
      ox4_r   <= ox3_r;
      oy4_r   <= oy3_r;
      gca4_r  <= gca3_r;
    end
  end

  assign out_valid     = vld4_r;
  assign out_ad        = ad4_r;
  assign out_side.ox   = ox4_r;
  assign out_side.oy   = oy4_r;
  assign out_side.band = band4_r;
  assign out_side.gca  = gca4_r;

endmodule

/* design/wvd_div.sv */
// pipelined restoring divider: table index = distance * depth / half width
// one quotient bit per stage; depends on wvd_pkg
module wvd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [wvd_pkg::SPAN_W-1:0] hw,
  input  logic                       in_valid,
  input  wvd_pkg::side_t             in_side,
  input  logic [wvd_pkg::DW-1:0]     in_ad,
  output logic                       out_valid,
  output wvd_pkg::side_t             out_side,
  output logic [wvd_pkg::KW-1:0]     out_k
);

  localparam int KW = wvd_pkg::KW;
  localparam int HW = wvd_pkg::SPAN_W;
  localparam int NW = HW + KW;

  logic [HW-1:0]      rem_r  [KW];
  logic [KW-1:0]      rest_r [KW];
  logic [KW-1:0]      quo_r  [KW+1];
  wvd_pkg::side_t     side_r [KW+1];
  logic               vld_r  [KW+1];

  // prep: numerator; outside the band the remainder starts at zero
  logic [HW-1:0] ad_in;
  logic [NW-1:0] num;

  always_comb begin
    ad_in = in_side.band ? in_ad[HW-1:0] : '0;
    num   = NW'(ad_in) * NW'(wvd_pkg::COS_TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num[NW-1:KW];
      rest_r[0] <= num[KW-1:0];
      quo_r[0]  <= '0;
      side_r[0] <= in_side;
    end
  end

  // one compare and subtract per stage
  for (genvar s = 1; s <= KW; s++) begin : g_step
    logic [HW:0]   trial;
    logic          take;
    logic [KW-1:0] quo_nxt;

    always_comb begin
      trial   = {rem_r[s-1], rest_r[s-1][KW-1]};
      take    = (trial >= {1'b0, hw});
      quo_nxt = {quo_r[s-1][KW-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s]  <= quo_nxt;
        side_r[s] <= side_r[s-1];
      end
    end

    if (s < KW) begin : g_rem
      logic [HW-1:0] rem_nxt;

      assign rem_nxt = take ? HW'(trial - {1'b0, hw}) : trial[HW-1:0];

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s]  <= rem_nxt;
          rest_r[s] <= {rest_r[s-1][KW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_r[KW];
  assign out_side  = side_r[KW];
  assign out_k     = quo_r[KW];

endmodule

/* design/wvd_warp.sv */
// back stages: cosine weight lookup, shift product, final add and saturation
// depends on wvd_pkg (table builder, side and result types)
module wvd_warp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  wvd_pkg::side_t         in_side,
  input  logic [wvd_pkg::KW-1:0] in_k,
  output logic                   out_valid,
  output wvd_pkg::res_t          out_res
);

  localparam int DW    = wvd_pkg::DW;
  localparam int CW    = wvd_pkg::COORD_WIDTH;
  localparam int GCA_W = wvd_pkg::GCA_W;
  localparam int W_W   = wvd_pkg::W_W;
  localparam int LO_W  = 19;
  localparam int PL_W  = LO_W + W_W;
  localparam int PH_W  = GCA_W - LO_W + W_W + 1;
  localparam int PW    = 56;
  localparam int SH_W  = PW - 32;
  localparam int FW    = (CW > DW + 1) ? CW : DW + 1;

  localparam logic signed [FW-1:0] SAT_HI = FW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [FW-1:0] SAT_LO = ~SAT_HI;

  localparam wvd_pkg::cos_rom_t COS_ROM = wvd_pkg::build_cos_rom();

  function automatic logic [CW-1:0] sat_coord(input logic [FW-1:0] v);
    if ($signed(v) > SAT_HI) begin
      return SAT_HI[CW-1:0];
    end else if ($signed(v) < SAT_LO) begin
      return SAT_LO[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  // stage 1: weight table read
  logic [W_W-1:0] w1_r;
  wvd_pkg::side_t side1_r;
  logic           vld1_r;

  // stage 2: split product of amplitude term and weight
  logic [PL_W-1:0] pl2_r, pl2_nxt;
  logic [PH_W-1:0] ph2_r, ph2_nxt;
  wvd_pkg::side_t  side2_r;
  logic            vld2_r;

  always_comb begin
    pl2_nxt = PL_W'(side1_r.gca[LO_W-1:0]) * PL_W'(w1_r);
    ph2_nxt = $signed(side1_r.gca[GCA_W-1:LO_W]) * $signed({1'b0, w1_r});
  end

  // stage 3: recombine with the rounding half
  logic [PW-1:0]  prod3_r, prod3_nxt;
  wvd_pkg::side_t side3_r;
  logic           vld3_r;

  assign prod3_nxt = (PW'($signed(ph2_r)) << LO_W) + PW'(pl2_r) + (PW'(1) << 31);

  // stage 4: apply the shift inside the band, then saturate
  logic [SH_W-1:0] shift4;
  logic [FW-1:0]   x4, y4;
  wvd_pkg::res_t   res4_r, res4_nxt;
  logic            vld4_r;

  always_comb begin
    shift4 = prod3_r[PW-1:32];
    x4     = FW'($signed(side3_r.ox))
           + (side3_r.band ? FW'($signed(shift4)) : FW'(0));
    y4     = FW'($signed(side3_r.oy));
    res4_nxt.pos_x   = sat_coord(x4);
    res4_nxt.pos_y   = sat_coord(y4);
    res4_nxt.in_band = side3_r.band;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      w1_r    <= COS_ROM[in_k];
      side1_r <= in_side;
      pl2_r   <= pl2_nxt;
      ph2_r   <= ph2_nxt;
      side2_r <= side1_r;
      prod3_r <= prod3_nxt;
      side3_r <= side2_r;
      res4_r  <= res4_nxt;
    end
  end

  assign out_valid = vld4_r;
  assign out_res   = res4_r;

endmodule

/* design/wave_vertex_displace_core.sv */
// Wave vertex displace core: maps one mesh vertex per transfer to a screen
// position and shifts its x inside a cosine-weighted wave band.
// Input channel: in_valid / in_stall carry grid_x, grid_y, progress (Q1.16).
// Result channel: out_valid / out_stall carry pos_x, pos_y (Q16.4, saturated)
// and in_band. One result per accepted vertex, in order.
// Configuration: write cfg_wdata to register cfg_index when cfg_wr_en is high;
// write only while no vertex is in flight.
// Throughput: one vertex per cycle while in_stall is low, every stage advancing together.
// Path: out_valid rises once an accepted vertex has passed 4 mapping stages,
// the divider (one prep stage plus one quotient bit per stage), 4 weight and
// shift stages and the output register.
// Stall: the output register has a one-entry skid behind it; in_stall rises
// only when that skid is occupied, so the pipeline freezes as a whole without
// losing or repeating a transfer.
// Reset: synchronous, active low; clears all valid bits and the configuration registers to 0.
// depends on wvd_pkg, wvd_map, wvd_div, wvd_warp and the assertion macros
`include "wave_vertex_displace_core_macros.svh"

module wave_vertex_displace_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wvd_pkg::GRID_W-1:0]          in_grid_x,
  input  logic [wvd_pkg::GRID_W-1:0]          in_grid_y,
  input  logic [wvd_pkg::GRID_W-1:0]          in_progress,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wvd_pkg::COORD_WIDTH-1:0] out_pos_x,
  output logic signed [wvd_pkg::COORD_WIDTH-1:0] out_pos_y,
  output logic                                out_in_band,
  input  logic                                cfg_wr_en,
  input  logic [wvd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wvd_pkg::CRD_W-1:0]           cfg_wdata
);

  localparam int SPAN_W = wvd_pkg::SPAN_W;

  // configuration registers
  wvd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        wvd_pkg::CFG_ORIGIN_X:   cfg_r.origin_x   <= cfg_wdata;
        wvd_pkg::CFG_ORIGIN_Y:   cfg_r.origin_y   <= cfg_wdata;
        wvd_pkg::CFG_SPAN_X:     cfg_r.span_x     <= cfg_wdata[SPAN_W-1:0];
        wvd_pkg::CFG_SPAN_Y:     cfg_r.span_y     <= cfg_wdata[SPAN_W-1:0];
        wvd_pkg::CFG_WINDOW_TOP: cfg_r.window_top <= cfg_wdata;
        wvd_pkg::CFG_WAVE_AMP:   cfg_r.wave_amp   <= cfg_wdata;
        wvd_pkg::CFG_HALF_WIDTH: cfg_r.half_width <= cfg_wdata[SPAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // pipeline advance: frozen only while the skid entry is occupied
  logic skid_valid_r, skid_valid_nxt;
  logic en;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // stages
  logic                       map_valid;
  wvd_pkg::side_t             map_side;
  logic [wvd_pkg::DW-1:0]     map_ad;
  logic                       div_valid;
  wvd_pkg::side_t             div_side;
  logic [wvd_pkg::KW-1:0]     div_k;
  logic                       warp_valid;
  wvd_pkg::res_t              warp_res;

  wvd_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .grid_x    (in_grid_x),
    .grid_y    (in_grid_y),
    .progress  (in_progress),
    .out_valid (map_valid),
    .out_side  (map_side),
    .out_ad    (map_ad)
  );

  wvd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .hw        (cfg_r.half_width),
    .in_valid  (map_valid),
    .in_side   (map_side),
    .in_ad     (map_ad),
    .out_valid (div_valid),
    .out_side  (div_side),
    .out_k     (div_k)
  );

  wvd_warp u_warp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_valid),
    .in_side   (div_side),
    .in_k      (div_k),
    .out_valid (warp_valid),
    .out_res   (warp_res)
  );

  // output register with skid entry
  logic          out_valid_r, out_valid_nxt;
  wvd_pkg::res_t out_res_r, out_res_nxt;
  wvd_pkg::res_t skid_res_r, skid_res_nxt;
  logic          take;
  logic          arrive;

  always_comb begin
    take           = out_valid_r && !out_stall;
    arrive         = en && warp_valid;
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || take) begin
      out_valid_nxt  = skid_valid_r || arrive;
      out_res_nxt    = skid_valid_r ? skid_res_r : warp_res;
      skid_valid_nxt = 1'b0;
    end else if (arrive) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = warp_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_pos_x   = out_res_r.pos_x;
  assign out_pos_y   = out_res_r.pos_y;
  assign out_in_band = out_res_r.in_band;

  // skid entry only fills behind a held output
  `WVD_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  // a taken output is refilled from the skid entry, which then empties
  `WVD_ASSERT_NXT(a_skid_drains, clk, rst_n,
                  out_valid_r && !out_stall && skid_valid_r,
                  out_valid_r && !skid_valid_r)
  // a held skid entry stays while the receiver keeps stalling
  `WVD_ASSERT_NXT(a_skid_holds, clk, rst_n, skid_valid_r && out_stall, skid_valid_r)

endmodule
